// File: design/gctl_pkg.sv
// Shared types and constants for the glyph cache tag lookup.
package gctl_pkg;

  localparam int unsigned SLOT_COUNT_DEFAULT = 24;
  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned TAG_W = HEIGHT_W + CODE_W;
  localparam int unsigned SLOT_OUT_W = 5;
  localparam int unsigned TOTAL_W = 32;

  typedef struct packed {
    logic [HEIGHT_W-1:0] glyph_height;
    logic [CODE_W-1:0]   char_code;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [TOTAL_W-1:0]    hit_total;
    logic [TOTAL_W-1:0]    fill_total;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } gctl_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic out_free;
  } gctl_status_t;

endpackage

// File: design/gctl_ifs.sv
// Valid/ready channel interfaces for lookup requests and results.
interface gctl_req_if;
  logic              valid;
  logic              ready;
  gctl_pkg::req_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gctl_rsp_if;
  logic              valid;
  logic              ready;
  gctl_pkg::rsp_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/glyph_cache_tag_lookup.sv
// Glyph cache tag lookup: fully associative tag store with round-robin replacement.
//
// Channels: req (sink) carries glyph_height and char_code; rsp (source)
// carries hit, slot_index, hit_total and fill_total. A beat moves on a
// rising edge with valid and ready both high. Every lookup yields one result.
// The tags are walked one slot per cycle out of a single-port tag memory;
// the DRAIN state then empties the compare stage, and the COMMIT state
// commits the fill and loads the result register.
// One lookup is in work at a time; req.ready is high only between lookups.
// The result register frees the walk from the receiver: the next lookup may
// be taken and walked while a result waits, and it holds in commit until
// rsp.ready takes the waiting beat. A stalled beat holds its payload.
// Reset (rst, synchronous) clears all valid bits, the victim pointer and
// both totals at once; no clearing pass is needed. Tags need no reset.
module glyph_cache_tag_lookup #(
  parameter int unsigned SLOT_COUNT = gctl_pkg::SLOT_COUNT_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  gctl_req_if.sink  req,
  gctl_rsp_if.source rsp
);
  import gctl_pkg::*;

  gctl_cmd_t    cmd;
  gctl_status_t status;

  gctl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gctl_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .req_payload (req.payload),
    .cmd         (cmd),
    .status      (status),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
  );

endmodule

// File: design/gctl_ctrl.sv
// Controller: sequences accept, tag walk, drain, commit for one lookup.
module gctl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  gctl_pkg::gctl_status_t status,
  output gctl_pkg::gctl_cmd_t    cmd
);
  import gctl_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    COMMIT
  } state_t;

  state_t state;

  assign cmd.start  = req_valid && req_ready;
  assign cmd.issue  = (state == SCAN);
  assign cmd.commit = (state == COMMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      req_ready <= 1'b1;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid && req_ready) begin
            state     <= SCAN;
            req_ready <= 1'b0;
          end
        end
        SCAN: begin
          if (status.last_issue) begin
            state <= DRAIN;
          end
        end
        // last tag read is still in the compare stage
        DRAIN: begin
          state <= COMMIT;
        end
        COMMIT: begin
          if (status.out_free) begin
            state     <= IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: design/gctl_dpath.sv
// Datapath: tag memory, valid bits, compare stage, counters and result register.
module gctl_dpath #(
  parameter int unsigned SLOT_COUNT = gctl_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gctl_pkg::req_t         req_payload,
  input  gctl_pkg::gctl_cmd_t    cmd,
  output gctl_pkg::gctl_status_t status,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output gctl_pkg::rsp_t         rsp_payload
);
  import gctl_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // request tag held for the whole walk
  logic [TAG_W-1:0]   req_tag;

  // tag memory, one read or one write per cycle
  logic [TAG_W-1:0]   tag_mem [SLOT_COUNT];
  logic [TAG_W-1:0]   rd_tag;

  logic [SLOT_COUNT-1:0] slot_valid;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   cmp_idx;
  logic               cmp_live;

  logic               found;
  logic [IDX_W-1:0]   hit_slot;
  logic               have_empty;
  logic [IDX_W-1:0]   empty_slot;

  logic [IDX_W-1:0]   victim_ptr;
  logic [IDX_W-1:0]   victim_ptr_next;
  logic [IDX_W-1:0]   fill_slot;
  logic [IDX_W-1:0]   res_slot;
  logic [IDX_W+SLOT_OUT_W-1:0] res_slot_wide;

  logic [TOTAL_W-1:0] hit_count;
  logic [TOTAL_W-1:0] fill_count;
  logic [TOTAL_W-1:0] hit_count_next;
  logic [TOTAL_W-1:0] fill_count_next;

  assign status.last_issue = (scan_idx == LAST_IDX);
  assign status.out_free   = !rsp_valid || rsp_ready;

  assign victim_ptr_next = (victim_ptr == LAST_IDX) ? '0 : victim_ptr + 1'b1;
  assign fill_slot       = have_empty ? empty_slot : victim_ptr_next;
  assign res_slot        = found ? hit_slot : fill_slot;
  assign res_slot_wide   = {{SLOT_OUT_W{1'b0}}, res_slot};
  assign hit_count_next  = found ? hit_count + 1'b1 : hit_count;
  assign fill_count_next = found ? fill_count : fill_count + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.commit && !found) begin
      tag_mem[fill_slot] <= req_tag;
    end
    if (cmd.issue) begin
      rd_tag <= tag_mem[scan_idx];
    end
  end

  // walk index and compare stage
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_tag    <= {req_payload.glyph_height, req_payload.char_code};
      scan_idx   <= '0;
      found      <= 1'b0;
      have_empty <= 1'b0;
    end else begin
      if (cmd.issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmp_live) begin
        if (slot_valid[cmp_idx]) begin
          if (!found && rd_tag == req_tag) begin
            found    <= 1'b1;
            hit_slot <= cmp_idx;
          end
        end else if (!have_empty) begin
          have_empty <= 1'b1;
          empty_slot <= cmp_idx;
        end
      end
    end
    if (cmd.issue) begin
      cmp_idx <= scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live   <= 1'b0;
      slot_valid <= '0;
      victim_ptr <= '0;
      hit_count  <= '0;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      cmp_live <= cmd.issue;
      if (cmd.commit) begin
        hit_count  <= hit_count_next;
        fill_count <= fill_count_next;
        if (!found) begin
          slot_valid[fill_slot] <= 1'b1;
          if (!have_empty) begin
            victim_ptr <= victim_ptr_next;
          end
        end
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result register, loaded only when free so a stalled beat holds
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_payload.hit        <= found;
      rsp_payload.slot_index <= res_slot_wide[SLOT_OUT_W-1:0];
      rsp_payload.hit_total  <= hit_count_next;
      rsp_payload.fill_total <= fill_count_next;
    end
  end

endmodule

// File: design/gctl_checker.sv
// Port-level checks for the glyph cache tag lookup, bound to the top level.
module gctl_checker #(
  parameter int unsigned SLOT_COUNT = gctl_pkg::SLOT_COUNT_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input gctl_pkg::rsp_t rsp_payload
);
  import gctl_pkg::*;

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("channels not idle after reset");

  // one lookup at a time: no request is taken while a walk is in progress
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready ##1 !req_ready)
    else $error("request taken during a walk");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (SLOT_COUNT > 32) || (32'(rsp_payload.slot_index) < SLOT_COUNT))
    else $error("slot index beyond the slot count");

endmodule

bind glyph_cache_tag_lookup gctl_checker #(
  .SLOT_COUNT (SLOT_COUNT)
) u_gctl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
